// ===== src/xrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xrg_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [ACTION_W-1:0] ACT_MIX    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAW   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_AROUND = 2'd2;

    localparam logic [WORD_W-1:0] MIX_MULT    = 32'h0100_0193;
    localparam logic [WORD_W-1:0] AROUND_MASK = 32'h0fff_ffff;

    localparam int unsigned XS_SHIFT_A = 13;
    localparam int unsigned XS_SHIFT_B = 17;
    localparam int unsigned XS_SHIFT_C = 5;

    // register index taken from the word address
    localparam logic REG_AUTO_SEED = 1'b0;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t mix_step(input word_t st, input word_t ent);
        word_t prod;
        prod = st * MIX_MULT;
        return prod ^ ent;
    endfunction

    function automatic word_t xorshift_step(input word_t st);
        word_t x;
        x = st;
        x = x ^ (x << XS_SHIFT_A);
        x = x ^ (x >> XS_SHIFT_B);
        x = x ^ (x << XS_SHIFT_C);
        return x;
    endfunction

    // largest 2^n-1 not above the centre, capped at AROUND_MASK
    function automatic word_t around_mask(input word_t centre);
        word_t m;
        if (centre >= AROUND_MASK) begin
            return AROUND_MASK;
        end
        m = centre + 32'd1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        return m >> 1;
    endfunction

endpackage

`default_nettype wire

// ===== src/xorshift_random_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// xorshift32 random word source with one transaction per cycle. An input transaction
// carries action (mix, draw, draw around value) and value; it is taken into an input
// register, and from there the state update (constant multiply-xor or the
// 13/17/5 shift-xor network) and the result are computed in one pass and the result is
// written to the output register. A new transaction is accepted every cycle while
// the output register is free or drained, and mix or unused actions produce no output
// transaction. A draw that finds the state zero loads auto_seed_value (APB address 0)
// first. auto_seed_value is to be written by the user only while the block is idle;
// the block itself does not enforce this.

module xorshift_random_generator_top
    import xrg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [WORD_W-1:0]   pwdata,
    output logic      [WORD_W-1:0]   prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [WORD_W-1:0]   value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [WORD_W-1:0]   result
);

    word_t auto_seed;

    xrg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .auto_seed (auto_seed)
    );

    xrg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .auto_seed (auto_seed),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== src/xrg_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xrg_cfg
    import xrg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]  pwdata,
    output logic      [WORD_W-1:0]  prdata,
    output logic                    pready,
    output word_t                   auto_seed
);

    word_t auto_seed_reg;
    word_t auto_seed_next;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_AUTO_SEED);

    always_comb
    begin
        auto_seed_next = auto_seed_reg;
        if (wr_en)
        begin
            auto_seed_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_seed_reg <= '0;
        end
        else
        begin
            auto_seed_reg <= auto_seed_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_AUTO_SEED: prdata = auto_seed_reg;
            default:       prdata = '0;
        endcase
    end

    assign auto_seed = auto_seed_reg;

endmodule

`default_nettype wire

// ===== src/xrg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xrg_core
    import xrg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire word_t               auto_seed,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [WORD_W-1:0]   value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [WORD_W-1:0]   result
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [ACTION_W-1:0] s1_action_reg;
    word_t               s1_value_reg;
    word_t               s1_mask_reg;

    word_t               state_reg;
    word_t               state_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    word_t               result_reg;
    word_t               result_next;

    logic                in_accept;
    logic                out_free;
    logic                s1_has_result;
    logic                s1_fire;
    word_t               seeded;
    word_t               drawn;

    assign out_free      = !out_valid_reg || !out_stall;
    assign s1_has_result = (s1_action_reg == ACT_DRAW) || (s1_action_reg == ACT_AROUND);
    assign s1_fire       = s1_valid_reg && (!s1_has_result || out_free);
    assign in_stall      = s1_valid_reg && !s1_fire;
    assign in_accept     = in_valid && !in_stall;

    assign seeded = (state_reg == '0) ? auto_seed : state_reg;
    assign drawn  = xorshift_step(seeded);

    always_comb
    begin
        state_next  = state_reg;
        result_next = drawn;
        case (s1_action_reg)
            ACT_MIX:
            begin
                state_next = mix_step(state_reg, s1_value_reg);
            end
            ACT_DRAW:
            begin
                state_next = drawn;
            end
            ACT_AROUND:
            begin
                state_next  = drawn;
                result_next = (s1_value_reg - (s1_mask_reg >> 1)) + (drawn & s1_mask_reg);
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_value_reg  <= value;
            s1_mask_reg   <= around_mask(value);
        end
        if (s1_fire && s1_has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // stall only while a transaction is held in the input register
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_has_result) |=> out_valid_reg)
        else $error("draw left no result");

    a_seeded_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_has_result && (seeded != '0)) |=> (state_reg != '0))
        else $error("seeded draw left a zero state");

    a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_mask_reg & 32'(s1_mask_reg + 32'd1)) == '0))
        else $error("mask not of the form 2^n-1");

    a_mask_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_mask_reg <= s1_value_reg) && (s1_mask_reg <= AROUND_MASK)))
        else $error("mask above centre or cap");

endmodule

`default_nettype wire

// ===== sim/xorshift_random_generator_top_tb.sv =====
`timescale 1ns / 1ps

module xorshift_random_generator_top_tb;
    import xrg_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
    localparam logic [PADDR_W-1:0]  SEED_ADDR   = {REG_AUTO_SEED, 2'b00};
    localparam int                  PHASES      = 5;
    localparam int                  PHASE_ITEMS = 220;
    localparam int                  HOLD_CYCLES = 150;
    localparam int                  CYCLE_LIMIT = 200000;
    localparam int                  DIR_ROWS    = 23;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        word_t               val;
        logic                known;
        word_t               want;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    word_t               pwdata    = '0;
    word_t               prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action    = ACT_MIX;
    word_t               value     = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    word_t               result;

    word_t expected_words[$];
    word_t model_state = '0;
    word_t model_seed  = '0;
    int    errors      = 0;
    int    cycles      = 0;
    int    hold_left   = 0;
    bit    hold_req    = 1'b0;
    bit    hold_taken  = 1'b0;
    bit    quiet       = 1'b0;

    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{ACT_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_AROUND, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_AROUND, 32'hffff_ffff, 1'b1, 32'hf800_0000},
        '{ACT_UNUSED, 32'hffff_ffff, 1'b0, 32'h0000_0000},
        '{ACT_DRAW,   32'hffff_ffff, 1'b1, 32'h0000_0000},
        '{ACT_MIX,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_MIX,    32'hffff_ffff, 1'b0, 32'h0000_0000},
        '{ACT_DRAW,   32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h0000_0001, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h0000_0002, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h0000_0003, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h0fff_fffe, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h0fff_ffff, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h1000_0000, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{ACT_UNUSED, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ACT_MIX,    32'h1234_5678, 1'b0, 32'h0000_0000},
        '{ACT_MIX,    32'ha5a5_a5a5, 1'b0, 32'h0000_0000},
        '{ACT_DRAW,   32'h5a5a_5a5a, 1'b0, 32'h0000_0000},
        '{ACT_AROUND, 32'h5a5a_5a5a, 1'b0, 32'h0000_0000},
        '{ACT_DRAW,   32'h0000_0000, 1'b0, 32'h0000_0000}
    };

    xorshift_random_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    always #6 clk = ~clk;

    function automatic word_t advance_word();
        word_t x;
        x = (model_state == '0) ? model_seed : model_state;
        x = x ^ (x << XS_SHIFT_A);
        x = x ^ (x >> XS_SHIFT_B);
        x = x ^ (x << XS_SHIFT_C);
        model_state = x;
        return x;
    endfunction

    function automatic bit predict_word(input logic [ACTION_W-1:0] act, input word_t val,
                                        output word_t word);
        word_t span;
        word = '0;
        case (act)
            ACT_MIX:
            begin
                model_state = (model_state * MIX_MULT) ^ val;
                return 1'b0;
            end
            ACT_DRAW:
            begin
                word = advance_word();
                return 1'b1;
            end
            ACT_AROUND:
            begin
                span = AROUND_MASK;
                while (span > val)
                begin
                    span = span >> 1;
                end
                word = (val - (span >> 1)) + (advance_word() & span);
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input word_t val,
                             input logic known, input word_t want);
        word_t word;
        while (!quiet && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (predict_word(act, val, word))
        begin
            expected_words.push_back(known ? want : word);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input word_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= SEED_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (!wr && prdata !== data)
        begin
            $error("prdata: expected %h, got %h", data, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_seed(input word_t seed);
        apb_xfer(1'b1, seed);
        model_seed = seed;
        @(posedge clk);
        apb_xfer(1'b0, seed);
    endtask

    task automatic random_item(output bit counted);
        int    roll;
        word_t val;
        roll    = $urandom_range(0, 99);
        val     = $urandom;
        counted = 1'b1;
        if (roll < 5)
        begin
            // entropy chosen so that the state returns to zero
            send_item(ACT_MIX, model_state * MIX_MULT, 1'b0, '0);
        end
        else if (roll < 28)
        begin
            send_item(ACT_MIX, val, 1'b0, '0);
        end
        else if (roll < 58)
        begin
            send_item(ACT_DRAW, val, 1'b0, '0);
        end
        else if (roll < 95)
        begin
            send_item(ACT_AROUND, val >> $urandom_range(0, 31), 1'b0, '0);
        end
        else
        begin
            send_item(ACT_UNUSED, val, 1'b0, '0);
            counted = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin : result_check
        word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result: expected no transaction, got %h", result);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result !== want)
                begin
                    $error("result: expected %h, got %h", want, result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        word_t seeds [0:PHASES-1];
        int    sent;
        bit    counted;
        seeds = '{32'hffff_ffff, 32'h0000_0001, $urandom, 32'h8000_0000, 32'h0000_0000};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].act, dir_rows[i].val, dir_rows[i].known, dir_rows[i].want);
        end
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_seed(seeds[p]);
            quiet = (p == 1);
            if (p == 2)
            begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                random_item(counted);
                if (counted)
                begin
                    sent++;
                end
                if (p == 3 && counted && sent == PHASE_ITEMS / 2)
                begin
                    // sender rests until the block has returned everything
                    in_valid <= 1'b0;
                    do @(posedge clk); while (expected_words.size() != 0);
                end
            end
            drain();
        end
        quiet = 1'b0;

        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
